// ----- design/bmfb_pkg.sv -----
// shared types and constants for the banded mono framebuffer blitter
// no dependencies; imported by the front, back and top-level modules of the block
`timescale 1ns / 1ps
`default_nettype none

package bmfb_pkg;

   // default geometry
   localparam int PANEL_WIDTH_DEF   = 800;
   localparam int PANEL_HEIGHT_DEF  = 480;
   localparam int ROW_BYTES_DEF     = 100;
   localparam int BAND_ROWS_MAX_DEF = 64;

   // operation codes
   localparam logic [1:0] OP_FILL = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_GET  = 2'd2;
   localparam logic [1:0] OP_BLIT = 2'd3;

   // register indexes and reset values
   localparam logic       CSR_IDX_Y_OFFSET   = 1'b0;
   localparam logic       CSR_IDX_BAND_ROWS  = 1'b1;
   localparam logic [10:0] Y_OFFSET_RESET    = 11'd0;
   localparam logic [6:0]  BAND_ROWS_RESET   = 7'd64;

   // fill bytes, stored 1 is white
   localparam logic [7:0] FILL_BLACK_BYTE = 8'h00;
   localparam logic [7:0] FILL_WHITE_BYTE = 8'hFF;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [11:0] x_coord;
      logic signed [11:0] y_coord;
      logic               color_black;
      logic [7:0]         src_byte;
      logic [3:0]         src_bits;
      logic               transparent;
   } bmfb_req_type;

   typedef struct packed {
      logic       pixel_black;
      logic [3:0] pixels_written;
   } bmfb_rsp_type;

   typedef struct packed {
      logic [10:0] band_y_offset;
      logic [6:0]  band_rows;
   } bmfb_cfg_type;

   typedef enum logic [1:0] {
      KIND_FILL  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_GET   = 2'd2
   } bmfb_kind_type;

   // classified command handed from front to back (addresses travel beside it)
   typedef struct packed {
      bmfb_kind_type kind;
      logic          use0;        // first byte touched
      logic          use1;        // second byte touched
      logic          get_hit;     // get pixel lands inside the band
      logic [2:0]    bit_sel;     // bit of first byte read by get
      logic [15:0]   wmask;       // bits to write over both bytes, msb first
      logic [15:0]   wdata;       // stored values for those bits
      logic [3:0]    count;       // pixels written
      logic          fill_black;
   } bmfb_cmd_type;

endpackage

`default_nettype wire

// ----- design/bmfb_ram.sv -----
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bmfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 6400
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/bmfb_queue.sv -----
// short fifo between the classifying front and the executing back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bmfb_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue pushed while full");

   a_count_up : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ----- design/bmfb_front.sv -----
// front end: takes items, clips them against panel and band, builds commands
// depends on bmfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmfb_front #(
   parameter int PANEL_WIDTH   = bmfb_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT  = bmfb_pkg::PANEL_HEIGHT_DEF,
   parameter int ROW_BYTES     = bmfb_pkg::ROW_BYTES_DEF,
   parameter int BAND_ROWS_MAX = bmfb_pkg::BAND_ROWS_MAX_DEF,
   parameter int AW            = 13
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire bmfb_pkg::bmfb_req_type req_item,
   input  wire bmfb_pkg::bmfb_cfg_type cfg,
   input  wire logic                   q_full,
   output logic                        q_push,
   output bmfb_pkg::bmfb_cmd_type      cmd,
   output logic [AW-1:0]               addr0,
   output logic [AW-1:0]               addr1,
   output logic [AW:0]                 fill_len
);

   import bmfb_pkg::*;

   logic         item_valid_ff, item_valid_in;
   bmfb_req_type item_ff;
   logic         accept;

   logic [11:0]        rows_held;
   logic signed [12:0] row;
   logic               row_ok;
   logic [3:0]         nbits;
   logic [7:0]         active;
   logic [7:0]         values;
   logic [7:0]         en8;
   logic signed [12:0] col;
   logic [AW-1:0]      base;
   logic [AW-1:0]      b0_ext;

   assign busy   = item_valid_ff & q_full;
   assign accept = start & ~busy;
   assign q_push = item_valid_ff & ~q_full;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (q_push) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   // band row and clipping
   always_comb begin
      rows_held = ({5'b0, cfg.band_rows} > 12'(BAND_ROWS_MAX)) ?
                  12'(BAND_ROWS_MAX) : {5'b0, cfg.band_rows};
      row    = $signed({item_ff.y_coord[11], item_ff.y_coord}) -
               $signed({2'b0, cfg.band_y_offset});
      row_ok = !item_ff.y_coord[11] &&
               ({1'b0, item_ff.y_coord} < 13'(PANEL_HEIGHT)) &&
               !row[12] && (row[11:0] < rows_held);
      nbits  = (item_ff.src_bits > 4'd8) ? 4'd8 : item_ff.src_bits;
   end

   // per pixel enables, pixel 0 in bit 7
   always_comb begin
      active = '0;
      values = '0;
      en8    = '0;
      col    = '0;
      unique case (item_ff.opcode)
         OP_SET: begin
            active = 8'h80;
            values = {~item_ff.color_black, 7'b0};
         end
         OP_GET: begin
            active = 8'h80;
         end
         OP_BLIT: begin
            for (int i = 0; i < 8; i++) begin
               active[7-i] = (4'(i) < nbits) &&
                             !(item_ff.transparent && item_ff.src_byte[7-i]);
            end
            values = item_ff.src_byte;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 8; i++) begin
         col = $signed({item_ff.x_coord[11], item_ff.x_coord}) + 13'(i);
         en8[7-i] = active[7-i] && row_ok && !col[12] &&
                    ({1'b0, col[11:0]} < 13'(PANEL_WIDTH)) &&
                    (col[11:3] < 9'(ROW_BYTES));
      end
   end

   // addresses, modular in AW bits so a first byte left of the panel still
   // gives the right second byte
   always_comb begin
      b0_ext   = AW'($signed(item_ff.x_coord[11:3]));
      base     = AW'(row[11:0]) * AW'(ROW_BYTES);
      addr0    = base + b0_ext;
      addr1    = base + b0_ext + AW'(1);
      fill_len = (AW + 1)'(rows_held) * (AW + 1)'(ROW_BYTES);
   end

   always_comb begin
      cmd            = '0;
      cmd.fill_black = item_ff.color_black;
      cmd.bit_sel    = ~item_ff.x_coord[2:0];
      unique case (item_ff.opcode)
         OP_FILL: begin
            cmd.kind = KIND_FILL;
         end
         OP_GET: begin
            cmd.kind    = KIND_GET;
            cmd.get_hit = en8[7];
         end
         OP_SET, OP_BLIT: begin
            cmd.kind  = KIND_WRITE;
            cmd.wmask = {en8, 8'b0} >> item_ff.x_coord[2:0];
            cmd.wdata = {values & en8, 8'b0} >> item_ff.x_coord[2:0];
            cmd.use0  = |cmd.wmask[15:8];
            cmd.use1  = |cmd.wmask[7:0];
            cmd.count = 4'($countones(en8));
         end
         default: begin
            cmd.kind = KIND_FILL;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/bmfb_back.sv -----
// back end: runs commands against the band store and drives the result
// depends on bmfb_pkg and bmfb_ram
`timescale 1ns / 1ps
`default_nettype none

module bmfb_back #(
   parameter int DEPTH = bmfb_pkg::BAND_ROWS_MAX_DEF * bmfb_pkg::ROW_BYTES_DEF,
   parameter int AW    = 13
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire bmfb_pkg::bmfb_cmd_type cmd,
   input  wire logic [AW-1:0]          addr0,
   input  wire logic [AW-1:0]          addr1,
   input  wire logic [AW:0]            fill_len,
   output logic                        q_pop,
   output logic                        rsp_strobe,
   output bmfb_pkg::bmfb_rsp_type      rsp_result
);

   import bmfb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_BYTE0 = 4'b0010,
      ST_BYTE1 = 4'b0100,
      ST_FILL  = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [AW-1:0]  fill_idx_ff, fill_idx_in;
   logic           rsp_valid_ff;
   bmfb_rsp_type   rsp_ff;
   logic           done;
   logic           black;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    rd_data, wr_data;

   bmfb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      fill_idx_in = fill_idx_ff;
      rd_en       = 1'b0;
      rd_addr     = addr0;
      wr_en       = 1'b0;
      wr_addr     = addr0;
      wr_data     = '0;
      done        = 1'b0;
      black       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               priority if (cmd.kind == KIND_FILL) begin
                  if (fill_len == '0) begin
                     done = 1'b1;
                  end else begin
                     state_in = ST_FILL;
                  end
               end else if ((cmd.kind == KIND_GET && cmd.get_hit) ||
                            (cmd.kind == KIND_WRITE && cmd.use0)) begin
                  rd_en    = 1'b1;
                  state_in = ST_BYTE0;
               end else if (cmd.kind == KIND_WRITE && cmd.use1) begin
                  rd_en    = 1'b1;
                  rd_addr  = addr1;
                  state_in = ST_BYTE1;
               end else begin
                  done = 1'b1;
               end
            end
         end
         ST_BYTE0: begin
            if (cmd.kind == KIND_GET) begin
               black    = ~rd_data[cmd.bit_sel];
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               wr_en   = 1'b1;
               wr_data = (rd_data & ~cmd.wmask[15:8]) | (cmd.wdata[15:8] & cmd.wmask[15:8]);
               if (cmd.use1) begin
                  rd_en    = 1'b1;
                  rd_addr  = addr1;
                  state_in = ST_BYTE1;
               end else begin
                  done     = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BYTE1: begin
            wr_en    = 1'b1;
            wr_addr  = addr1;
            wr_data  = (rd_data & ~cmd.wmask[7:0]) | (cmd.wdata[7:0] & cmd.wmask[7:0]);
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = fill_idx_ff;
            wr_data = cmd.fill_black ? FILL_BLACK_BYTE : FILL_WHITE_BYTE;
            if ({1'b0, fill_idx_ff} + (AW + 1)'(1) == fill_len) begin
               fill_idx_in = '0;
               done        = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               fill_idx_in = fill_idx_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign q_pop = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_idx_ff  <= fill_idx_in;
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff.pixel_black    <= black;
         rsp_ff.pixels_written <= cmd.count;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   a_pop_gives_result : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_strobe)
      else $error("command retired without a result");

   a_no_rd_wr_clash : assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && rd_addr == wr_addr))
      else $error("store read and written at one address");

   a_fill_idx_rest : assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_FILL |-> fill_idx_ff == '0)
      else $error("fill index not back at zero");

endmodule

`default_nettype wire

// ----- design/banded_mono_framebuffer_blitter_core.sv -----
// top level of the banded mono framebuffer blitter: csr block, front, queue, back
// depends on bmfb_pkg, bmfb_front, bmfb_queue, bmfb_back (and bmfb_ram below it)
`timescale 1ns / 1ps
`default_nettype none

// Holds one horizontal band of a 1 bit per pixel panel (stored 1 = white,
// row-major, msb first) and executes fill, set pixel, get pixel and blit byte
// commands. A command is taken at a clock edge with start high and busy low;
// every command returns exactly one result, shown for one cycle with
// rsp_strobe high, and the receiver cannot stall it. The front stage
// registers and clips the command and hands it through a two-entry queue to
// the back stage, which owns the single-write, single-read band store; the
// front keeps taking commands while the back works, so busy only rises when
// the queue is full and the front holds a waiting command. Back-end work per
// command is set by the read-modify-write on the store: a command that
// touches nothing (clipped away, or get outside the band) retires from idle;
// get and set or blit within one byte read the byte, then write it back
// (get returns the bit instead); a blit that spans two bytes does this for
// each byte in turn; fill writes min(band_rows, BAND_ROWS_MAX) * ROW_BYTES
// bytes (one byte written per cycle). The result strobe is registered from
// the back end's retire and also waits out the queue. The store has no reset
// and no clearing pass: software fills the band before reading from it.
// band_y_offset and band_rows are written over the apb-style csr port and
// may only change while no command is outstanding.

module banded_mono_framebuffer_blitter_core #(
   parameter int PANEL_WIDTH   = bmfb_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT  = bmfb_pkg::PANEL_HEIGHT_DEF,
   parameter int ROW_BYTES     = bmfb_pkg::ROW_BYTES_DEF,
   parameter int BAND_ROWS_MAX = bmfb_pkg::BAND_ROWS_MAX_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire bmfb_pkg::bmfb_req_type req_item,
   // result channel
   output logic                        rsp_strobe,
   output bmfb_pkg::bmfb_rsp_type      rsp_result,
   // csr port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [2:0]             csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   import bmfb_pkg::*;

   localparam int STORE_DEPTH = BAND_ROWS_MAX * ROW_BYTES;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CMD_W       = $bits(bmfb_cmd_type);
   localparam int QW          = CMD_W + 2 * AW + AW + 1;
   localparam int QUEUE_DEPTH = 2;

   // ---------------------------------------------------------------------
   // csr block: two registers, written on the access phase of a transaction
   // ---------------------------------------------------------------------
   bmfb_cfg_type cfg_ff, cfg_in;
   logic         csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_IDX_Y_OFFSET:  cfg_in.band_y_offset = csr_pwdata[10:0];
            CSR_IDX_BAND_ROWS: cfg_in.band_rows     = csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_y_offset <= Y_OFFSET_RESET;
         cfg_ff.band_rows     <= BAND_ROWS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read-back, no wait states
   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_Y_OFFSET:  csr_prdata = {21'b0, cfg_ff.band_y_offset};
         CSR_IDX_BAND_ROWS: csr_prdata = {25'b0, cfg_ff.band_rows};
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // front: accept and classify
   // ---------------------------------------------------------------------
   logic          q_full, q_push, q_pop, q_valid;
   bmfb_cmd_type  f_cmd, b_cmd;
   logic [AW-1:0] f_addr0, f_addr1, b_addr0, b_addr1;
   logic [AW:0]   f_fill_len, b_fill_len;
   logic [QW-1:0] q_in, q_out;

   bmfb_front #(
      .PANEL_WIDTH   (PANEL_WIDTH),
      .PANEL_HEIGHT  (PANEL_HEIGHT),
      .ROW_BYTES     (ROW_BYTES),
      .BAND_ROWS_MAX (BAND_ROWS_MAX),
      .AW            (AW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .cmd      (f_cmd),
      .addr0    (f_addr0),
      .addr1    (f_addr1),
      .fill_len (f_fill_len)
   );

   // ---------------------------------------------------------------------
   // command queue: decouples classification from store access
   // ---------------------------------------------------------------------
   assign q_in = {f_cmd, f_addr0, f_addr1, f_fill_len};

   bmfb_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_out)
   );

   assign {b_cmd, b_addr0, b_addr1, b_fill_len} = q_out;

   // ---------------------------------------------------------------------
   // back: read-modify-write, get and fill walk on the band store
   // ---------------------------------------------------------------------
   bmfb_back #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .cmd        (b_cmd),
      .addr0      (b_addr0),
      .addr1      (b_addr1),
      .fill_len   (b_fill_len),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_result (rsp_result)
   );

endmodule

`default_nettype wire
